### rtl/ry420_pkg.sv
// Shared types and constants for the RGB to YCbCr 4:2:0 packer.
package ry420_pkg;

  localparam int PIX_W            = 8;
  localparam int CFG_W            = 11;
  localparam int MC_OUT_W         = 10;
  localparam int LINE_W           = 2 * PIX_W;
  localparam int RESET_HALF_WIDTH = 320;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pipe_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
  } ycc_t;

endpackage

### rtl/ry420_csc.sv
// Two-stage color space converter: registered coefficient products, then sums and saturation.
module ry420_csc import ry420_pkg::*; #(
  parameter int FRAC = 16
) (
  input  logic             clk,
  input  pipe_ctl_t        ctl,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] blue,
  output ycc_t             pix_r
);

  localparam int PW = FRAC + PIX_W;
  localparam int SW = FRAC + PIX_W + 2;

  localparam logic [FRAC-1:0] K_Y_R  = FRAC'(((64'd2990 << FRAC) + 64'd5000) / 64'd10000);
  localparam logic [FRAC-1:0] K_Y_G  = FRAC'(((64'd5870 << FRAC) + 64'd5000) / 64'd10000);
  localparam logic [FRAC-1:0] K_Y_B  = FRAC'(((64'd1140 << FRAC) + 64'd5000) / 64'd10000);
  localparam logic [FRAC-1:0] K_CB_R = FRAC'(((64'd1687 << FRAC) + 64'd5000) / 64'd10000);
  localparam logic [FRAC-1:0] K_CB_G = FRAC'(((64'd3313 << FRAC) + 64'd5000) / 64'd10000);
  localparam logic [FRAC-1:0] K_HALF = FRAC'(((64'd5000 << FRAC) + 64'd5000) / 64'd10000);
  localparam logic [FRAC-1:0] K_CR_G = FRAC'(((64'd4187 << FRAC) + 64'd5000) / 64'd10000);
  localparam logic [FRAC-1:0] K_CR_B = FRAC'(((64'd813 << FRAC) + 64'd5000) / 64'd10000);
  localparam logic [SW-1:0]   OFFSET = SW'(64'd128 << FRAC);

  logic [PW-1:0] p_yr_r, p_yg_r, p_yb_r;
  logic [PW-1:0] p_cbr_r, p_cbg_r, p_hb_r;
  logic [PW-1:0] p_hr_r, p_crg_r, p_crb_r;

  logic [SW-1:0] y_sum;
  logic [SW-1:0] cb_pos, cb_neg;
  logic [SW-1:0] cr_pos, cr_neg;
  ycc_t          pix_nxt;

  function automatic logic [PIX_W-1:0] sat_floor(input logic [SW-1:0] s);
    logic [SW-1:0] v;
    v = s >> FRAC;
    return (v > SW'(255)) ? 8'hFF : v[PIX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      p_yr_r  <= PW'(K_Y_R) * PW'(red);
      p_yg_r  <= PW'(K_Y_G) * PW'(green);
      p_yb_r  <= PW'(K_Y_B) * PW'(blue);
      p_cbr_r <= PW'(K_CB_R) * PW'(red);
      p_cbg_r <= PW'(K_CB_G) * PW'(green);
      p_hb_r  <= PW'(K_HALF) * PW'(blue);
      p_hr_r  <= PW'(K_HALF) * PW'(red);
      p_crg_r <= PW'(K_CR_G) * PW'(green);
      p_crb_r <= PW'(K_CR_B) * PW'(blue);
    end
  end

  always_comb begin
    y_sum  = SW'(p_yr_r) + SW'(p_yg_r) + SW'(p_yb_r);
    cb_pos = OFFSET + SW'(p_hb_r);
    cb_neg = SW'(p_cbr_r) + SW'(p_cbg_r);
    cr_pos = OFFSET + SW'(p_hr_r);
    cr_neg = SW'(p_crg_r) + SW'(p_crb_r);
    pix_nxt.y  = sat_floor(y_sum);
    pix_nxt.cb = (cb_neg > cb_pos) ? '0 : sat_floor(cb_pos - cb_neg);
    pix_nxt.cr = (cr_neg > cr_pos) ? '0 : sat_floor(cr_pos - cr_neg);
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

### rtl/ry420_line_ram.sv
// Line buffer for top-row luma pairs: one write port, one registered read port.
module ry420_line_ram import ry420_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [LINE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [LINE_W-1:0] rd_data_r
);

  logic [LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### rtl/rgb_to_ycbcr420_packer.sv
// Top level: RGB pixel stream to packed YCbCr 4:2:0 macro pixels.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    in_red, in_green, in_blue, in_frame_start
//   out      out_valid/out_ready  out_y_*, out_chroma_*, out_macro_column
//   cfg      cfg_valid/cfg_ready  cfg_half_width (cfg_ready is always high)
//
// One pixel item per clock sustained while the output is not stalled; a macro pixel
// reaches the output after the edge that takes its bottom-right pixel (products
// load on that edge, then the sum stage and the output register).
// The line RAM takes one write and one read per cycle; entries are not cleared,
// so the block is ready as soon as reset is released.
// A stalled output backs up through the two pipeline stages to in_ready.
module rgb_to_ycbcr420_packer import ry420_pkg::*; #(
  parameter int MAX_HALF_WIDTH  = 1024,
  parameter int COEFF_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIX_W-1:0]    in_red,
  input  logic [PIX_W-1:0]    in_green,
  input  logic [PIX_W-1:0]    in_blue,
  input  logic                in_frame_start,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PIX_W-1:0]    out_y_top_left,
  output logic [PIX_W-1:0]    out_y_top_right,
  output logic [PIX_W-1:0]    out_y_bottom_left,
  output logic [PIX_W-1:0]    out_y_bottom_right,
  output logic [PIX_W-1:0]    out_chroma_blue,
  output logic [PIX_W-1:0]    out_chroma_red,
  output logic [MC_OUT_W-1:0] out_macro_column,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_half_width
);

  localparam int CLW    = $clog2(2 * MAX_HALF_WIDTH);
  localparam int AW     = CLW - 1;
  localparam int RST_HW = (RESET_HALF_WIDTH > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH
                                                              : RESET_HALF_WIDTH;
  localparam logic [CLW-1:0] RST_LAST = CLW'(2 * RST_HW - 1);

  logic [CLW-1:0] last_col_r, last_col_nxt;
  logic [CLW-1:0] col_r, col_nxt, col_cur;
  logic           odd_r, odd_nxt, odd_cur;
  logic [31:0]    hw_eff;
  logic           in_acc;

  logic           s1_valid_r, s1_odd_col_r, s1_odd_row_r;
  logic [AW-1:0]  s1_mc_r;
  logic           s2_valid_r, s2_odd_col_r, s2_odd_row_r;
  logic [AW-1:0]  s2_mc_r;
  logic           s1_adv, s2_adv, s2_emit;

  pipe_ctl_t      ctl;
  ycc_t           pix;
  logic [PIX_W-1:0]  held_r;
  logic              rd_en, wr_en;
  logic [LINE_W-1:0] top_pair;
  logic [AW+MC_OUT_W-1:0] mc_ext;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_ytl_r, out_ytr_r, out_ybl_r, out_ybr_r, out_cb_r, out_cr_r;
  logic [MC_OUT_W-1:0] out_mc_r;

  // configuration: clamp half width and keep the last column index
  assign cfg_ready = 1'b1;

  always_comb begin
    hw_eff = 32'(cfg_half_width);
    if (hw_eff == 32'd0) begin
      hw_eff = 32'd1;
    end else if (hw_eff > 32'(MAX_HALF_WIDTH)) begin
      hw_eff = 32'(MAX_HALF_WIDTH);
    end
    last_col_nxt = CLW'(2 * hw_eff - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= RST_LAST;
    end else if (cfg_valid && cfg_ready) begin
      last_col_r <= last_col_nxt;
    end
  end

  // pipeline flow control
  assign s2_emit  = s2_odd_col_r && s2_odd_row_r;
  assign s2_adv   = s2_valid_r && !(s2_emit && out_valid_r && !out_ready);
  assign s1_adv   = s1_valid_r && (!s2_valid_r || s2_adv);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign ctl.s1_load = in_acc;
  assign ctl.s2_load = s1_adv;

  // raster position
  always_comb begin
    col_cur = in_frame_start ? '0 : col_r;
    odd_cur = in_frame_start ? 1'b0 : odd_r;
    if (col_cur >= last_col_r) begin
      col_nxt = '0;
      odd_nxt = !odd_cur;
    end else begin
      col_nxt = col_cur + CLW'(1);
      odd_nxt = odd_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      odd_r <= 1'b0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      odd_r <= odd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (!s2_valid_r || s2_adv) begin
        s2_valid_r <= s1_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_odd_col_r <= col_cur[0];
      s1_odd_row_r <= odd_cur;
      s1_mc_r      <= col_cur[CLW-1:1];
    end
    if (s1_adv) begin
      s2_odd_col_r <= s1_odd_col_r;
      s2_odd_row_r <= s1_odd_row_r;
      s2_mc_r      <= s1_mc_r;
    end
  end

  ry420_csc #(
    .FRAC (COEFF_FRAC_BITS)
  ) u_csc (
    .clk   (clk),
    .ctl   (ctl),
    .red   (in_red),
    .green (in_green),
    .blue  (in_blue),
    .pix_r (pix)
  );

  // top row writes its pair when the odd column leaves; bottom row reads on entry
  assign rd_en = s1_adv && s1_odd_col_r && s1_odd_row_r;
  assign wr_en = s2_adv && s2_odd_col_r && !s2_odd_row_r;

  ry420_line_ram #(
    .DEPTH (MAX_HALF_WIDTH),
    .AW    (AW)
  ) u_line_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (s2_mc_r),
    .wr_data   ({pix.y, held_r}),
    .rd_en     (rd_en),
    .rd_addr   (s1_mc_r),
    .rd_data_r (top_pair)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (s2_adv && !s2_odd_col_r) begin
      held_r <= pix.y;
    end
  end

  // output register
  assign mc_ext = {MC_OUT_W'(0), s2_mc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv && s2_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_emit) begin
      out_ytl_r <= top_pair[PIX_W-1:0];
      out_ytr_r <= top_pair[LINE_W-1:PIX_W];
      out_ybl_r <= held_r;
      out_ybr_r <= pix.y;
      out_cb_r  <= pix.cb;
      out_cr_r  <= pix.cr;
      out_mc_r  <= mc_ext[MC_OUT_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_y_top_left     = out_ytl_r;
  assign out_y_top_right    = out_ytr_r;
  assign out_y_bottom_left  = out_ybl_r;
  assign out_y_bottom_right = out_ybr_r;
  assign out_chroma_blue    = out_cb_r;
  assign out_chroma_red     = out_cr_r;
  assign out_macro_column   = out_mc_r;

`ifndef SYNTHESIS
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en && (s2_mc_r == s1_mc_r)))
    else $error("line RAM read and write hit the same entry");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && s2_emit) |=> out_valid)
    else $error("macro pixel lost at output register");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with empty pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_adv) |=> (s2_valid_r && $stable(s2_mc_r)))
    else $error("stalled stage lost its item");
`endif

endmodule
